// ----- rtl/pcd_pkg.sv -----
// pcd_pkg: shared types, constants and helper functions for the prefix-code decoder.
// No dependencies; compiled first.
`default_nettype none

package pcd_pkg;

  localparam int TABLE_ENTRIES_DEF = 256;
  localparam int MAX_CODE_LEN_DEF  = 32;

  localparam int SYM_W  = 8;
  localparam int LEN_W  = 6;
  localparam int CODE_W = 32;

  // Priority search is split into groups of GROUP_W match bits
  localparam int GROUP_W    = 16;
  localparam int GIDX_W     = 4;
  localparam int MAX_GROUPS = 16;

  // Result queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;
  localparam int QCNT_W      = 3;

  typedef enum logic {
    CMD_DECODE = 1'b0,
    CMD_LOAD   = 1'b1
  } pcd_cmd_t;

  typedef enum logic {
    STATUS_OK  = 1'b0,
    STATUS_ERR = 1'b1
  } pcd_status_t;

  // Front -> back: one classified decode event
  typedef struct packed {
    logic                                 vld;
    logic                                 err;
    logic [MAX_GROUPS-1:0]                grp_hit;
    logic [MAX_GROUPS-1:0][GIDX_W-1:0]    grp_idx;
  } pcd_evt_t;

  // Back -> front: queue occupancy for credit check
  typedef struct packed {
    logic [QCNT_W-1:0] fill;
  } pcd_qstat_t;

  typedef struct packed {
    logic [SYM_W-1:0] symbol;
    logic             status;
  } pcd_res_t;

  // Mask of the low len bits of a 32-bit code
  function automatic logic [CODE_W-1:0] low_mask32(input logic [LEN_W-1:0] len);
    logic [CODE_W-1:0] m;
    m = '0;
    for (int i = 0; i < CODE_W; i++) begin
      if (i < int'(len)) m[i] = 1'b1;
    end
    return m;
  endfunction

  // Index of lowest set bit in a group (0 if none)
  function automatic logic [GIDX_W-1:0] lowest_idx(input logic [GROUP_W-1:0] v);
    logic [GIDX_W-1:0] idx;
    idx = '0;
    for (int i = GROUP_W - 1; i >= 0; i--) begin
      if (v[i]) idx = GIDX_W'(i);
    end
    return idx;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/pcd_if.sv -----
// pcd_if: valid/ready channel interfaces for the decoder's input and result streams.
// Depends on pcd_pkg for field widths.
`default_nettype none

interface pcd_in_if import pcd_pkg::*;;
  logic              valid;
  logic              ready;
  logic              cmd;
  logic              bit_in;
  logic [SYM_W-1:0]  entry_symbol;
  logic [LEN_W-1:0]  entry_length;
  logic [CODE_W-1:0] entry_code;

  modport source (output valid, cmd, bit_in, entry_symbol, entry_length, entry_code,
                  input ready);
  modport sink   (input valid, cmd, bit_in, entry_symbol, entry_length, entry_code,
                  output ready);
  modport mon    (input valid, ready, cmd, bit_in, entry_symbol, entry_length,
                  entry_code);
endinterface

interface pcd_out_if import pcd_pkg::*;;
  logic             valid;
  logic             ready;
  logic [SYM_W-1:0] symbol_out;
  logic             status;

  modport source (output valid, symbol_out, status, input ready);
  modport sink   (input valid, symbol_out, status, output ready);
  modport mon    (input valid, ready, symbol_out, status);
endinterface

`default_nettype wire

// ----- rtl/pcd_front.sv -----
// pcd_front: code table cells, bit accumulator, parallel match and first search stage.
// Depends on pcd_pkg and pcd_if.
`default_nettype none

module pcd_front import pcd_pkg::*; #(
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
  parameter int MAX_CODE_LEN  = MAX_CODE_LEN_DEF
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  pcd_in_if.sink      in_chan,
  input  pcd_qstat_t  qstat,
  output pcd_evt_t    evt
);

  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W = $clog2(MAX_CODE_LEN + 1);
  localparam int CB_W  = (MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W;
  localparam int CMP_W = (CNT_W > LEN_W) ? CNT_W : LEN_W;
  localparam int NGRP  = (TABLE_ENTRIES + GROUP_W - 1) / GROUP_W;
  localparam int PAD   = NGRP * GROUP_W;

  logic [LEN_W-1:0]        len_r  [TABLE_ENTRIES];
  logic [CB_W-1:0]         code_r [TABLE_ENTRIES];
  logic [MAX_CODE_LEN-1:0] acc_r, acc_nxt, acc_shift;
  logic [MAX_CODE_LEN:0]   acc_cat;
  logic [CNT_W-1:0]        cnt_r, cnt_nxt, cnt_inc;

  logic                    accept, dec, load;
  logic [PAD-1:0]          match;
  logic                    any_match, hit_err;

  logic                    s1_vld_r, s1_err_r;
  logic [PAD-1:0]          s1_match_r;
  pcd_evt_t                evt_nxt, evt_r;

  logic [QCNT_W:0]         inflight;

  assign accept = in_chan.valid & in_chan.ready;
  assign dec    = accept & (in_chan.cmd == CMD_DECODE);
  assign load   = accept & (in_chan.cmd == CMD_LOAD) &
                  ({1'b0, in_chan.entry_symbol} < (SYM_W + 1)'(TABLE_ENTRIES));

  // Table cells: code stored pre-masked to its length
  for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
    logic we;
    assign we = load & (in_chan.entry_symbol[IDX_W-1:0] == IDX_W'(i));

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        len_r[i] <= '0;
      end else if (we) begin
        len_r[i] <= in_chan.entry_length;
      end
    end

    always_ff @(posedge clk) begin
      if (we) begin
        code_r[i] <= CB_W'(in_chan.entry_code & low_mask32(in_chan.entry_length));
      end
    end

    assign match[i] = (len_r[i] != '0) &&
                      (CMP_W'(len_r[i]) == CMP_W'(cnt_inc)) &&
                      (MAX_CODE_LEN'(code_r[i]) == acc_shift);
  end

  if (PAD > TABLE_ENTRIES) begin : g_pad
    assign match[PAD-1:TABLE_ENTRIES] = '0;
  end

  assign acc_cat   = {acc_r, in_chan.bit_in};
  assign acc_shift = acc_cat[MAX_CODE_LEN-1:0];
  assign cnt_inc   = cnt_r + 1'b1;  // cnt_r never holds MAX_CODE_LEN
  assign any_match = |match;
  assign hit_err   = ~any_match & (cnt_inc == CNT_W'(MAX_CODE_LEN));

  always_comb begin
    acc_nxt = acc_r;
    cnt_nxt = cnt_r;
    if (dec) begin
      if (any_match || hit_err) begin
        acc_nxt = '0;
        cnt_nxt = '0;
      end else begin
        acc_nxt = acc_shift;
        cnt_nxt = cnt_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r    <= '0;
      cnt_r    <= '0;
      s1_vld_r <= 1'b0;
    end else begin
      acc_r    <= acc_nxt;
      cnt_r    <= cnt_nxt;
      s1_vld_r <= dec & (any_match | hit_err);
    end
  end

  always_ff @(posedge clk) begin
    s1_err_r   <= hit_err;
    s1_match_r <= match;
  end

  // Group stage: per-group hit and lowest index
  always_comb begin
    evt_nxt     = '0;
    evt_nxt.vld = s1_vld_r;
    evt_nxt.err = s1_err_r;
    for (int g = 0; g < NGRP; g++) begin
      evt_nxt.grp_hit[g] = |s1_match_r[g*GROUP_W +: GROUP_W];
      evt_nxt.grp_idx[g] = lowest_idx(s1_match_r[g*GROUP_W +: GROUP_W]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      evt_r.vld <= 1'b0;
    end else begin
      evt_r.vld <= evt_nxt.vld;
    end
    evt_r.err     <= evt_nxt.err;
    evt_r.grp_hit <= evt_nxt.grp_hit;
    evt_r.grp_idx <= evt_nxt.grp_idx;
  end

  assign evt = evt_r;

  // Credit: queued plus in-flight events must leave room for one more
  assign inflight      = {1'b0, qstat.fill} + (QCNT_W + 1)'(s1_vld_r) +
                         (QCNT_W + 1)'(evt_r.vld);
  assign in_chan.ready = (inflight < (QCNT_W + 1)'(QUEUE_DEPTH));

endmodule

`default_nettype wire

// ----- rtl/pcd_back.sv -----
// pcd_back: final symbol select and result queue driving the output channel.
// Depends on pcd_pkg and pcd_if.
`default_nettype none

module pcd_back import pcd_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  pcd_evt_t    evt,
  output pcd_qstat_t  qstat,
  pcd_out_if.source   out_chan
);

  pcd_res_t          q_mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic [GIDX_W-1:0] grp_sel;
  pcd_res_t          res;
  logic              push, pop;

  assign grp_sel = lowest_idx(evt.grp_hit);

  always_comb begin
    if (evt.err) begin
      res.symbol = '0;
      res.status = STATUS_ERR;
    end else begin
      res.symbol = {grp_sel, evt.grp_idx[grp_sel]};
      res.status = STATUS_OK;
    end
  end

  assign push = evt.vld;  // front holds credit, queue never overflows
  assign pop  = out_chan.valid & out_chan.ready;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r + QCNT_W'(push) - QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr_r] <= res;
    end
  end

  assign out_chan.valid      = (cnt_r != '0);
  assign out_chan.symbol_out = q_mem[rd_ptr_r].symbol;
  assign out_chan.status     = q_mem[rd_ptr_r].status;
  assign qstat.fill          = cnt_r;

endmodule

`default_nettype wire

// ----- rtl/prefix_code_decoder_core.sv -----
// prefix_code_decoder_core: top level of the serial prefix-code decoder.
// Depends on pcd_pkg, pcd_if, pcd_front and pcd_back.
//
//   Channel   Dir   Handshake     Payload
//   in_chan   in    valid/ready   cmd, bit_in, entry_symbol, entry_length, entry_code
//   out_chan  out   valid/ready   symbol_out, status
//
// One input transaction, load or decode, per cycle while in_chan.ready is high.
// A decode bit is matched against every table cell in the cycle it arrives; the
// winning symbol is found over two more register stages and then queued.
// Reset (rst_n low, synchronous) marks all table entries unused and empties the
// accumulator, pipeline and result queue; code bits are not cleared.
// in_chan.ready drops only when the 4-entry result queue plus in-flight events
// would fill up, i.e. when out_chan has been stalled.
`default_nettype none

module prefix_code_decoder_core import pcd_pkg::*; #(
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
  parameter int MAX_CODE_LEN  = MAX_CODE_LEN_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  pcd_in_if.sink     in_chan,
  pcd_out_if.source  out_chan
);

  pcd_evt_t   evt;    // classified decode event, front -> back
  pcd_qstat_t qstat;  // queue fill, back -> front

  // Front: table load, bit accumulate, parallel match, group search
  pcd_front #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .MAX_CODE_LEN  (MAX_CODE_LEN)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .qstat   (qstat),
    .evt     (evt)
  );

  // Back: symbol select, result queue, output handshake
  pcd_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .evt      (evt),
    .qstat    (qstat),
    .out_chan (out_chan)
  );

endmodule

`default_nettype wire

// ----- rtl/pcd_checker.sv -----
// pcd_checker: port-level assertions for prefix_code_decoder_core, plus its bind.
// Depends on pcd_pkg; the bind taps the top level's channel ports.
`default_nettype none

module pcd_checker import pcd_pkg::*; (
  input wire logic             clk,
  input wire logic             rst_n,
  input wire logic             in_valid,
  input wire logic             in_ready,
  input wire logic             in_cmd,
  input wire logic             out_valid,
  input wire logic             out_ready,
  input wire logic [SYM_W-1:0] out_symbol_out,
  input wire logic             out_status
);

  // Stalled result holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=>
      out_valid && $stable(out_symbol_out) && $stable(out_status))
    else $error("result changed while stalled");

  // Error results carry symbol zero
  a_err_sym: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == STATUS_ERR) |-> out_symbol_out == '0)
    else $error("error result with nonzero symbol");

  // Nothing is offered right after reset
  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // A result appears on an empty output only after an accepted decode transaction
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |->
      $past(in_valid && in_ready && (in_cmd == CMD_DECODE), 3))
    else $error("result without matching decode transaction");

endmodule

bind prefix_code_decoder_core pcd_checker u_pcd_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_chan.valid),
  .in_ready       (in_chan.ready),
  .in_cmd         (in_chan.cmd),
  .out_valid      (out_chan.valid),
  .out_ready      (out_chan.ready),
  .out_symbol_out (out_chan.symbol_out),
  .out_status     (out_chan.status)
);

`default_nettype wire
